[src/assert_macros.svh]
// Assertion helpers included by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define GESV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset
`define GESV_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gesv_pkg.sv]
package gesv_pkg;

  localparam int COEFF_W     = 32;
  localparam int DIM_W       = 5;
  localparam int ROW_IDX_W   = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] DIM_RESET     = 5'd4;
  // register select is paddr bit 2 (word index)
  localparam logic             REG_DIMENSION = 1'b0;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
    logic               ovf;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    E_PIV_RD, E_PIV_WT, E_M_RD, E_M_WT, E_DIV,
    E_K_RDI, E_K_RDJ, E_K_MUL, E_K_SUB,
    B_ROW, B_K_RD, B_K_MUL, B_K_SAT, B_K_ACC,
    B_R_RD, B_R_WT, B_D_WT, B_DIV, B_NEXT,
    O_RD, O_WT, O_HOLD
  } back_state_t;

  // clamp a wide signed value to the 32-bit range
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t res;
    if (v > 64'sd2147483647) begin
      res.val = Q_MAX;
      res.ovf = 1'b1;
    end else if (v < -64'sd2147483648) begin
      res.val = Q_MIN;
      res.ovf = 1'b1;
    end else begin
      res.val = v[31:0];
      res.ovf = 1'b0;
    end
    return res;
  endfunction

endpackage

[src/gesv_stream_if.sv]
interface gesv_in_if import gesv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff;

  modport source (output valid, output coeff, input ready);
  modport sink (input valid, input coeff, output ready);
endinterface

interface gesv_out_if import gesv_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COEFF_W-1:0]   solution;
  logic        [ROW_IDX_W-1:0] row_index;
  logic                        last;
  logic                        zero_pivot;
  logic                        saturated;

  modport source (output valid, output solution, output row_index, output last,
                  output zero_pivot, output saturated, input ready);
  modport sink (input valid, input solution, input row_index, input last,
                input zero_pivot, input saturated, output ready);
endinterface

[src/gesv_fifo.sv]
module gesv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt != CW'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == LAST_PTR) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == LAST_PTR) ? '0 : rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

endmodule

[src/gesv_front.sv]
module gesv_front import gesv_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic [IDX_W-1:0]              n,
  gesv_in_if.sink                       in_ch,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [1+2*IDX_W+COEFF_W-1:0]  q_data
);

  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic             accept;
  logic             end_row;
  logic             last;

  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid;
  assign accept      = in_ch.valid & q_ready;
  assign end_row     = (col == n);
  assign last        = end_row && (row == n - 1'b1);
  // tagged item: last-of-run flag, position, element
  assign q_data      = {last, row, col, in_ch.coeff};

  // row/column position of the next element
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (end_row) begin
        col <= '0;
        row <= last ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

[src/gesv_div.sv]
module gesv_div import gesv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          neg;
  logic [31:0]   dmag;
  logic [32:0]   rem;
  logic [QW-1:0] dsh;
  logic [QW-1:0] quot;
  logic [32:0]   rem_t;
  logic          ge;
  logic          pos_ovf;
  logic          neg_ovf;

  // one restoring step per cycle
  assign rem_t = {rem[31:0], dsh[QW-1]};
  assign ge    = (rem_t >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitudes, remainder, quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg  <= req.dividend[31] ^ req.divisor[31];
      dmag <= req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
      dsh  <= {(req.dividend[31] ? 32'(-req.dividend) : 32'(req.dividend)),
               FRAC_BITS'(0)};
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_t - {1'b0, dmag} : rem_t;
      quot <= {quot[QW-2:0], ge};
      dsh  <= {dsh[QW-2:0], 1'b0};
    end
  end

  // signed result with clamping
  assign pos_ovf = |quot[QW-1:31];
  assign neg_ovf = (|quot[QW-1:32]) | (quot[31] & (|quot[30:0]));

  always_comb begin
    rsp.done = done;
    if (neg) begin
      rsp.ovf  = neg_ovf;
      rsp.quot = neg_ovf ? Q_MIN : -$signed(quot[31:0]);
    end else begin
      rsp.ovf  = pos_ovf;
      rsp.quot = pos_ovf ? Q_MAX : $signed(quot[31:0]);
    end
  end

endmodule

[src/gesv_back.sv]
module gesv_back import gesv_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16,
  parameter int IDX_W     = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDX_W-1:0]              n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [1+2*IDX_W+COEFF_W-1:0]  q_data,
  gesv_out_if.source                    out_ch
);

  localparam int ROW_LEN = MAX_DIM + 1;
  localparam int DEPTH   = MAX_DIM * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(MAX_DIM);
  localparam int ITEM_W  = 1 + 2 * IDX_W + COEFF_W;

  back_state_t state, state_next;

  // unpacked queue item
  logic signed [31:0] item_coeff;
  logic [IDX_W-1:0]   item_col;
  logic [IDX_W-1:0]   item_row;
  logic               item_last;

  assign item_coeff = q_data[COEFF_W-1:0];
  assign item_col   = q_data[COEFF_W +: IDX_W];
  assign item_row   = q_data[COEFF_W+IDX_W +: IDX_W];
  assign item_last  = q_data[ITEM_W-1];

  // matrix memory, one write and one registered read port
  logic signed [31:0] mem [DEPTH];
  logic [IDX_W-1:0]   rd_row, rd_col, wr_row, wr_col;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data, rd_data;

  // solution memory
  logic signed [31:0] sol_mem [MAX_DIM];
  logic               sol_we;
  logic [SW-1:0]      sol_wi, sol_ri;
  logic signed [31:0] sol_wd, sol_rd;

  // loop indices and working values
  logic [IDX_W-1:0]   i, j, k;
  logic signed [31:0] p, m, s, r, ajk, mq;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               zp, sat;
  sat_t               mul_sat, sub_k, acc, rsub;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gesv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign rd_addr = AW'(int'(rd_row) * ROW_LEN + int'(rd_col));
  assign wr_addr = AW'(int'(wr_row) * ROW_LEN + int'(wr_col));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sol_we) sol_mem[sol_wi] <= sol_wd;
    sol_rd <= sol_mem[sol_ri];
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rounding toward minus infinity is the arithmetic shift
  assign mul_sat = sat32(prod >>> FRAC_BITS);
  assign sub_k   = sat32(64'(ajk) - 64'(mq));
  assign acc     = sat32(64'(s) + 64'(mq));
  assign rsub    = sat32(64'(rd_data) - 64'(s));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next       = state;
    q_ready          = 1'b0;
    rd_row           = i;
    rd_col           = i;
    wr_en            = 1'b0;
    wr_row           = item_row;
    wr_col           = item_col;
    wr_data          = item_coeff;
    sol_we           = 1'b0;
    sol_wi           = j[SW-1:0];
    sol_wd           = div_rsp.quot;
    sol_ri           = k[SW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = p;
    mul_a            = m;
    mul_b            = rd_data;
    unique case (state)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          wr_en = 1'b1;
          if (item_last) state_next = E_PIV_RD;
        end
      end
      E_PIV_RD: begin
        if (({1'b0, i} + 1'b1) >= {1'b0, n}) state_next = B_ROW;
        else                                  state_next = E_PIV_WT;
      end
      E_PIV_WT: begin
        state_next = (rd_data == 32'sd0) ? E_PIV_RD : E_M_RD;
      end
      E_M_RD: begin
        rd_row = j;
        rd_col = i;
        state_next = (j >= n) ? E_PIV_RD : E_M_WT;
      end
      E_M_WT: begin
        div_req.start = 1'b1;
        state_next    = E_DIV;
      end
      E_DIV: begin
        if (div_rsp.done) state_next = E_K_RDI;
      end
      E_K_RDI: begin
        rd_row = i;
        rd_col = k;
        state_next = (k > n) ? E_M_RD : E_K_RDJ;
      end
      E_K_RDJ: begin
        rd_row = j;
        rd_col = k;
        state_next = E_K_MUL;
      end
      E_K_MUL: begin
        state_next = E_K_SUB;
      end
      E_K_SUB: begin
        wr_en      = 1'b1;
        wr_row     = j;
        wr_col     = k;
        wr_data    = sub_k.val;
        state_next = E_K_RDI;
      end
      B_ROW: begin
        state_next = B_K_RD;
      end
      B_K_RD: begin
        rd_row = j;
        rd_col = k;
        state_next = (k >= n) ? B_R_RD : B_K_MUL;
      end
      B_K_MUL: begin
        mul_a      = rd_data;
        mul_b      = sol_rd;
        state_next = B_K_SAT;
      end
      B_K_SAT: begin
        state_next = B_K_ACC;
      end
      B_K_ACC: begin
        state_next = B_K_RD;
      end
      B_R_RD: begin
        rd_row = j;
        rd_col = n;
        state_next = B_R_WT;
      end
      B_R_WT: begin
        rd_row = j;
        rd_col = j;
        state_next = B_D_WT;
      end
      B_D_WT: begin
        if (rd_data == 32'sd0) begin
          sol_we     = 1'b1;
          sol_wd     = 32'sd0;
          state_next = B_NEXT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = r;
          div_req.divisor  = rd_data;
          state_next       = B_DIV;
        end
      end
      B_DIV: begin
        if (div_rsp.done) begin
          sol_we     = 1'b1;
          state_next = B_NEXT;
        end
      end
      B_NEXT: begin
        state_next = (j == '0) ? O_RD : B_ROW;
      end
      O_RD: begin
        sol_ri     = i[SW-1:0];
        state_next = O_WT;
      end
      O_WT: begin
        state_next = O_HOLD;
      end
      O_HOLD: begin
        if (out_ch.ready) state_next = out_ch.last ? ST_LOAD : O_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // loop counters, working registers and flags
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (q_valid && item_last) begin
          i   <= '0;
          zp  <= 1'b0;
          sat <= 1'b0;
        end
      end
      E_PIV_RD: begin
        if (({1'b0, i} + 1'b1) >= {1'b0, n}) j <= n - 1'b1;
      end
      E_PIV_WT: begin
        p <= rd_data;
        if (rd_data == 32'sd0) begin
          zp <= 1'b1;
          i  <= i + 1'b1;
        end else begin
          j <= i + 1'b1;
        end
      end
      E_M_RD: begin
        if (j >= n) i <= i + 1'b1;
      end
      E_DIV: begin
        if (div_rsp.done) begin
          m   <= div_rsp.quot;
          sat <= sat | div_rsp.ovf;
          k   <= i + 1'b1;
        end
      end
      E_K_RDI: begin
        if (k > n) j <= j + 1'b1;
      end
      E_K_MUL: begin
        ajk <= rd_data;
        mq  <= mul_sat.val;
        sat <= sat | mul_sat.ovf;
      end
      E_K_SUB: begin
        sat <= sat | sub_k.ovf;
        k   <= k + 1'b1;
      end
      B_ROW: begin
        s <= 32'sd0;
        k <= j + 1'b1;
      end
      B_K_SAT: begin
        mq  <= mul_sat.val;
        sat <= sat | mul_sat.ovf;
      end
      B_K_ACC: begin
        s   <= acc.val;
        sat <= sat | acc.ovf;
        k   <= k + 1'b1;
      end
      B_R_WT: begin
        r   <= rsub.val;
        sat <= sat | rsub.ovf;
      end
      B_D_WT: begin
        if (rd_data == 32'sd0) zp <= 1'b1;
      end
      B_DIV: begin
        if (div_rsp.done) sat <= sat | div_rsp.ovf;
      end
      B_NEXT: begin
        if (j == '0) i <= '0;
        else         j <= j - 1'b1;
      end
      O_HOLD: begin
        if (out_ch.ready && !out_ch.last) i <= i + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == O_WT) begin
      out_ch.valid <= 1'b1;
    end else if (state == O_HOLD && out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == O_WT) begin
      out_ch.solution   <= sol_rd;
      out_ch.row_index  <= ROW_IDX_W'(i);
      out_ch.last       <= (({1'b0, i} + 1'b1) == {1'b0, n});
      out_ch.zero_pivot <= zp;
      out_ch.saturated  <= sat;
    end
  end

endmodule

[src/gaussian_elimination_solver_top.sv]
// Linear system solver, Gaussian elimination without pivoting, Q16.16.
// Input channel in_ch carries the augmented matrix one element per
// transaction, row by row: n coefficients, then the right-hand side.
// Output channel out_ch returns the n solution components in index order,
// with last on the final one and the zero_pivot / saturated flags of the
// solve on every transaction. The dimension register (APB, byte address 0)
// sets n; 0 acts as 1 and values above MAX_DIM act as MAX_DIM. A write
// restarts loading. pready is tied high.
// Loading: one element per cycle into a 4-deep queue and the matrix RAM.
// Solve after the last element: an elimination update steps through
// E_K_RDI, E_K_RDJ, E_K_MUL and E_K_SUB on the single RAM read port, a
// division waits on the serial divider, a substitution term steps through
// B_K_RD, B_K_MUL, B_K_SAT and B_K_ACC, and a result O_RD, O_WT, O_HOLD.
// While solving or emitting, the queue keeps taking input until full.
// If the receiver stalls, the current result holds in the output
// register and the sequencer waits. Synchronous reset empties the queue,
// drops any result in flight and sets dimension to 4; RAM is not cleared.
module gaussian_elimination_solver_top import gesv_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  gesv_in_if.sink            in_ch,
  gesv_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(MAX_DIM + 2);
  localparam int ITEM_W = 1 + 2 * IDX_W + COEFF_W;

  logic [DIM_W-1:0]  dimension;
  logic [IDX_W-1:0]  n_eff;
  logic              cfg_wr;
  logic              q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [ITEM_W-1:0] q_in_data, q_out_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_DIMENSION);
  assign prdata = (paddr[2] == REG_DIMENSION) ? PDATA_W'(dimension) : '0;

  always_ff @(posedge clk) begin
    if (rst)         dimension <= DIM_RESET;
    else if (cfg_wr) dimension <= pwdata[DIM_W-1:0];
  end

  // clamp dimension into 1..MAX_DIM
  always_comb begin
    if (dimension == '0)                n_eff = IDX_W'(1);
    else if (int'(dimension) > MAX_DIM) n_eff = IDX_W'(MAX_DIM);
    else                                n_eff = IDX_W'(dimension);
  end

  gesv_front #(.IDX_W(IDX_W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wr),
    .n       (n_eff),
    .in_ch   (in_ch),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_data  (q_in_data)
  );

  gesv_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  gesv_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_back (
    .clk     (clk),
    .rst     (rst),
    .n       (n_eff),
    .q_valid (q_out_valid),
    .q_ready (q_out_ready),
    .q_data  (q_out_data),
    .out_ch  (out_ch)
  );

endmodule

[src/gesv_checker.sv]
`include "assert_macros.svh"

module gesv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] solution,
  input logic [3:0]  row_index,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // no result survives reset
  `GESV_ASSERT_NR(a_rst_clears_out, clk, rst |=> !out_valid, "result valid after reset")

  // stalled result holds
  `GESV_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(solution) && $stable(row_index), "stalled result changed")

  // dimension register is 5 bits wide
  `GESV_ASSERT(a_rd_width, clk, rst, psel && !pwrite |-> prdata[31:5] == 27'd0, "upper read bits set")

  // written dimension reads back
  `GESV_ASSERT(a_wr_readback, clk, rst, (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |-> prdata[4:0] == $past(pwdata[4:0]), "dimension read-back mismatch")

endmodule

bind gaussian_elimination_solver_top gesv_checker u_gesv_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .solution  (out_ch.solution),
  .row_index (out_ch.row_index),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

[verif/gaussian_elimination_solver_top_tb.sv]
module gaussian_elimination_solver_top_tb;
  import gesv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N       = 16;
  localparam int ROW_W       = MAX_N + 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;
  localparam int RANDOM_ITEMS = 90;

  // one solution component as seen on the output channel
  typedef struct {
    logic signed [31:0] solution;
    logic [3:0]         row_index;
    logic               last;
    logic               zero_pivot;
    logic               saturated;
  } solution_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  gesv_in_if  in_if();
  gesv_out_if out_if();

  gaussian_elimination_solver_top uut (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [31:0] matrix [MAX_N][ROW_W];
  logic signed [31:0] unknowns [MAX_N];
  logic [DIM_W-1:0]   dim_reg;
  int                 load_cnt;
  logic               pivot_flag, sat_flag;

  logic signed [31:0] coeff_q [$];
  solution_t          solution_q [$];
  int                 mismatches = 0;
  int                 send_gap = 0;
  int                 recv_gap = 0;
  longint             cycles = 0;

  function automatic logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // product shifted with floor rounding
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp(p >>> 16);
  endfunction

  // quotient truncated toward zero
  function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint num;
    num = longint'(a) * 64'sd65536;
    return clamp(num / longint'(b));
  endfunction

  function automatic int eff_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_N) return MAX_N;
    return int'(dim_reg);
  endfunction

  // forward elimination, back substitution, then queue the components
  function automatic void solve_system(int n);
    logic signed [31:0] piv, mult, acc, rem;
    solution_t r;
    pivot_flag = 1'b0;
    sat_flag   = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      piv = matrix[i][i];
      if (piv == 0) begin
        pivot_flag = 1'b1;
        continue;
      end
      for (int j = i + 1; j < n; j++) begin
        mult = fx_div(matrix[j][i], piv);
        matrix[j][i] = 0;
        for (int k = i + 1; k <= n; k++)
          matrix[j][k] = clamp(longint'(matrix[j][k]) -
                               longint'(fx_mul(mult, matrix[i][k])));
      end
    end
    for (int j = n - 1; j >= 0; j--) begin
      acc = 0;
      for (int k = j + 1; k < n; k++)
        acc = clamp(longint'(acc) + longint'(fx_mul(matrix[j][k], unknowns[k])));
      rem = clamp(longint'(matrix[j][n]) - longint'(acc));
      if (matrix[j][j] == 0) begin
        pivot_flag = 1'b1;
        unknowns[j] = 0;
      end else begin
        unknowns[j] = fx_div(rem, matrix[j][j]);
      end
    end
    for (int i = 0; i < n; i++) begin
      r.solution   = unknowns[i];
      r.row_index  = i[3:0];
      r.last       = (i == n - 1);
      r.zero_pivot = pivot_flag;
      r.saturated  = sat_flag;
      solution_q.push_back(r);
    end
  endfunction

  function automatic void absorb_coeff(logic signed [31:0] v);
    int n, total;
    n = eff_dim();
    total = n * (n + 1);
    if (load_cnt >= total) load_cnt = 0;
    matrix[load_cnt / (n + 1)][load_cnt % (n + 1)] = v;
    load_cnt++;
    if (load_cnt == total) begin
      load_cnt = 0;
      solve_system(n);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (coeff_q.size() > 0 && $urandom_range(99) >= send_gap) begin
        in_if.valid <= 1'b1;
        in_if.coeff <= coeff_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output monitor, receiver stalls and cycle limit
  always @(posedge clk) begin
    solution_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gaussian_elimination_solver_top] ERROR");
      $finish;
    end
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_gap);
      if (in_if.valid && in_if.ready) absorb_coeff(in_if.coeff);
      if (out_if.valid && out_if.ready) begin
        if (solution_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: solution %h row %0d", out_if.solution,
                     out_if.row_index);
        end else begin
          e = solution_q.pop_front();
          if (out_if.solution !== e.solution || out_if.row_index !== e.row_index ||
              out_if.last !== e.last || out_if.zero_pivot !== e.zero_pivot ||
              out_if.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch sol/row/last/zp/sat: exp %h %0d %b %b %b got %h %0d %b %b %b",
                       e.solution, e.row_index, e.last, e.zero_pivot, e.saturated,
                       out_if.solution, out_if.row_index, out_if.last, out_if.zero_pivot,
                       out_if.saturated);
          end
        end
      end
    end
  end

  // quiet means nothing pending, nothing in flight and nothing expected
  task automatic wait_quiet();
    do @(negedge clk);
    while (coeff_q.size() != 0 || in_if.valid || solution_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_dimension(logic [4:0] value);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DIMENSION, 2'b00};
    pwdata  <= {27'($urandom_range(0, 32'h7ffffff)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    dim_reg  = value;
    load_cnt = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [31:0] signed_rand(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // one full system: 0 well conditioned, 1 raw bits, 2 zero on the diagonal,
  // 3 values near the limits
  task automatic load_system(int n, int kind);
    int zrow;
    logic signed [31:0] v;
    zrow = $urandom_range(0, n - 1);
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        case (kind)
          1: v = $urandom;
          3: v = ($urandom_range(1)) ? 32'sh7fffffff - $urandom_range(0, 65535)
                                     : 32'sh80000000 + $urandom_range(0, 65535);
          default: begin
            if (c == n) v = signed_rand(1 << 22);
            else if (c == r) begin
              v = ($urandom_range(1, 8) << 16) | $urandom_range(0, 65535);
              if ($urandom_range(1)) v = -v;
              if (kind == 2 && r == zrow) v = 0;
            end else v = signed_rand(65536);
          end
        endcase
        coeff_q.push_back(v);
      end
  endtask

  initial begin
    int sent;
    int n, kind;
    in_if.valid  = 1'b0;
    in_if.coeff  = '0;
    out_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    dim_reg = DIM_RESET;
    load_cnt = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset dimension with extremes and sign patterns
    foreach (coeff_q[i]) ;
    coeff_q.push_back(32'sh7fffffff); coeff_q.push_back(32'sh80000000);
    coeff_q.push_back(0);             coeff_q.push_back(1);
    coeff_q.push_back(-1);            coeff_q.push_back(32'sh00010000);
    coeff_q.push_back(32'sh80000000); coeff_q.push_back(32'sh7fffffff);
    coeff_q.push_back(32'shffff0000); coeff_q.push_back(32'sh00008000);
    coeff_q.push_back(32'sh00020000); coeff_q.push_back(32'sh00010000);
    coeff_q.push_back(32'sh00000001); coeff_q.push_back(32'sh80000000);
    coeff_q.push_back(32'sh00030000); coeff_q.push_back(32'sh00010000);
    coeff_q.push_back(32'shfffffffe); coeff_q.push_back(32'sh00000000);
    coeff_q.push_back(32'sh7fffffff); coeff_q.push_back(32'sh00040000);
    // zero pivot during elimination
    set_dimension(5'd2);
    coeff_q.push_back(0); coeff_q.push_back(32'sh00010000); coeff_q.push_back(32'sh00010000);
    coeff_q.push_back(32'sh00010000); coeff_q.push_back(32'sh00010000);
    coeff_q.push_back(32'sh00020000);
    // dimension zero acts as one, zero pivot during substitution
    set_dimension(5'd0);
    coeff_q.push_back(0); coeff_q.push_back(32'sh00050000);
    // a write part way through loading restarts it
    set_dimension(5'd16);
    repeat (30) coeff_q.push_back($urandom);

    // random phases: sender light / receiver heavy, swapped, then none
    for (int mode = 0; mode < 3; mode++) begin
      send_gap = (mode == 0) ? 8 : (mode == 1) ? 51 : 0;
      recv_gap = (mode == 0) ? 51 : (mode == 1) ? 8 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        n = $urandom_range(1, 5);
        set_dimension(n[4:0]);
        repeat ($urandom_range(1, 3)) begin
          kind = $urandom_range(9);
          kind = (kind < 6) ? 0 : kind - 6;
          if (kind > 3) kind = 0;
          load_system(n, kind);
          sent += n * (n + 1);
        end
      end
    end
    // largest system with a zero on the diagonal, written as an
    // out-of-range value that clamps
    set_dimension(5'd31);
    load_system(MAX_N, 2);

    wait_quiet();
    if (mismatches == 0) begin
      $display("[gaussian_elimination_solver_top] OK");
    end else begin
      $display("[gaussian_elimination_solver_top] ERROR");
    end
    $finish;
  end

endmodule
